// ----- rtl/pidpi_pkg.sv -----
package pidpi_pkg;

	// Fixed field widths
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 15;
	localparam int DBAND_W    = 16;
	localparam int DRIVE_W    = 16;
	localparam int ACC_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_GAIN_P         = 3'd1,
		REG_GAIN_I         = 3'd2,
		REG_GAIN_D         = 3'd3,
		REG_DRIVE_LIMIT    = 3'd4,
		REG_INTEGRAL_LIMIT = 3'd5,
		REG_DEAD_BAND      = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		MODE_POSITION    = 1'b0,
		MODE_INCREMENTAL = 1'b1
	} pid_mode_t;

endpackage

// ----- rtl/pidpi_if.sv -----
interface pidpi_sample_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] setpoint;
	logic signed [SAMPLE_WIDTH-1:0] measured;

	modport source (output valid, output setpoint, output measured, input ready);
	modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pidpi_drive_if
	import pidpi_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface

// ----- rtl/pid_controller_pos_incr_unit.sv -----
// A sample transaction goes through the input register, the operand and product
// stages and the output register before its drive shows on the result channel.
// Throughput: one transaction per cycle unless stalled; the state loop (error
// sum, past errors) closes in stage 2, the held drive in the output stage.
// Reset (arst_n low): registers return to their defaults, state clears,
// pipeline empties. Any valid register write also clears the state.
module pid_controller_pos_incr_unit
	import pidpi_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pidpi_sample_if.sink          sample,
	pidpi_drive_if.source         result
);

	// Derived widths
	localparam int EW  = SAMPLE_WIDTH + 1;              // error
	localparam int PXW = SAMPLE_WIDTH + 2;              // proportional operand
	localparam int DXW = SAMPLE_WIDTH + 3;              // derivative operand
	localparam int IXW = (EW > ACC_W) ? EW : ACC_W;     // integral operand
	localparam int SAW = IXW + 1;                       // error sum before saturation
	localparam int CW  = (EW > DBAND_W) ? EW : DBAND_W; // dead band compare
	localparam int PPW = GAIN_W + PXW;
	localparam int IPW = GAIN_W + IXW;
	localparam int DPW = GAIN_W + DXW;
	localparam int YW  = ((DPW > PPW) ? DPW : PPW) + 2;  // drive sum

	// Configuration registers
	pid_mode_t                 mode_q;
	logic signed [GAIN_W-1:0]  gain_p_q;
	logic signed [GAIN_W-1:0]  gain_i_q;
	logic signed [GAIN_W-1:0]  gain_d_q;
	logic        [LIMIT_W-1:0] drive_limit_q;
	logic        [LIMIT_W-1:0] integral_limit_q;
	logic        [DBAND_W-1:0] dead_band_q;
	logic                      cfg_hit;

	// Controller state
	logic signed [ACC_W-1:0]   err_sum_q;
	logic signed [EW-1:0]      err_last_q;
	logic signed [EW-1:0]      err_prev_q;
	logic signed [DRIVE_W-1:0] drive_held_q;
	logic                      first_q;

	// Pipeline valids and flow control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic adv2, adv4;

	// Stage 1: input register
	logic signed [SAMPLE_WIDTH-1:0] setpoint_s1;
	logic signed [SAMPLE_WIDTH-1:0] measured_s1;

	// Stage 2: operands for the three products
	logic signed [PXW-1:0] p_x_s2;
	logic signed [IXW-1:0] i_x_s2;
	logic signed [DXW-1:0] d_x_s2;
	logic                  dz_s2;

	// Stage 3: scaled terms
	logic signed [PPW-1:0] term_p_s3;
	logic signed [IPW-1:0] term_i_s3;
	logic signed [DPW-1:0] term_d_s3;
	logic                  dz_s3;

	// Stage 4: output register
	logic signed [DRIVE_W-1:0] drive_s4;

	// Stage 2 combinational
	logic signed [EW-1:0]    err;
	logic signed [EW-1:0]    err_last_eff;
	logic        [EW-1:0]    err_mag;
	logic signed [SAW-1:0]   sum_wide;
	logic signed [ACC_W-1:0] sum_next;
	logic                    sum_ovf;
	logic signed [PXW-1:0]   p_x;
	logic signed [IXW-1:0]   i_x;
	logic signed [DXW-1:0]   d_x;

	// Stage 3 combinational
	logic signed [PPW-1:0] prod_p;
	logic signed [IPW-1:0] prod_i;
	logic signed [DPW-1:0] prod_d;

	// Stage 4 combinational
	logic signed [IPW-1:0]     ilim;
	logic signed [IPW-1:0]     term_i_cl;
	logic signed [YW-1:0]      lim;
	logic signed [YW-1:0]      held;
	logic signed [YW-1:0]      y_sum;
	logic signed [YW-1:0]      y_cl;
	logic signed [DRIVE_W-1:0] y_out;

	// Flow control: a stage loads when it is empty or its contents move on
	assign rdy4 = !v_s4 || result.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign adv2 = v_s1 && rdy2;
	assign adv4 = v_s3 && rdy4;

	assign sample.ready = rdy1;
	assign result.valid = v_s4;
	assign result.drive = drive_s4;

	// Register decode: an index past the last register is dropped and clears nothing
	always_comb begin
		case (cfg_reg_t'(cfg_idx))
			REG_MODE,
			REG_GAIN_P,
			REG_GAIN_I,
			REG_GAIN_D,
			REG_DRIVE_LIMIT,
			REG_INTEGRAL_LIMIT,
			REG_DEAD_BAND: cfg_hit = cfg_we;
			default:       cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= MODE_POSITION;
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			drive_limit_q    <= '1;
			integral_limit_q <= '1;
			dead_band_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_MODE:           mode_q           <= pid_mode_t'(cfg_data[0]);
				REG_GAIN_P:         gain_p_q         <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_I:         gain_i_q         <= $signed(cfg_data[GAIN_W-1:0]);
				REG_GAIN_D:         gain_d_q         <= $signed(cfg_data[GAIN_W-1:0]);
				REG_DRIVE_LIMIT:    drive_limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_DEAD_BAND:      dead_band_q      <= cfg_data[DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 2: error, saturating sum, operand selection per form
	always_comb begin
		err = EW'(setpoint_s1) - EW'(measured_s1);
		err_mag = err[EW-1] ? EW'($unsigned(-err)) : EW'($unsigned(err));

		// Position form seeds the past error with the current one on the first sample
		err_last_eff = (mode_q == MODE_POSITION && first_q) ? err : err_last_q;

		sum_wide = SAW'(err_sum_q) + SAW'(err);
		sum_ovf  = (sum_wide[SAW-1:ACC_W-1] != '0) && (sum_wide[SAW-1:ACC_W-1] != '1);
		if (!sum_ovf) begin
			sum_next = sum_wide[ACC_W-1:0];
		end else if (sum_wide[SAW-1]) begin
			sum_next = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sum_next = {1'b0, {(ACC_W-1){1'b1}}};
		end

		if (mode_q == MODE_POSITION) begin
			p_x = PXW'(err);
			i_x = IXW'(sum_next);
			d_x = DXW'(err) - DXW'(err_last_eff);
		end else begin
			p_x = PXW'(err) - PXW'(err_last_q);
			i_x = IXW'(err);
			d_x = DXW'(err) + DXW'(err_prev_q) - (DXW'(err_last_q) <<< 1);
		end
	end

	// State: advance with each item leaving stage 1, clear on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q    <= '0;
			err_last_q   <= '0;
			err_prev_q   <= '0;
			drive_held_q <= '0;
			first_q      <= 1'b1;
		end else if (cfg_hit) begin
			err_sum_q    <= '0;
			err_last_q   <= '0;
			err_prev_q   <= '0;
			drive_held_q <= '0;
			first_q      <= 1'b1;
		end else begin
			if (adv2) begin
				err_last_q <= err;
				if (mode_q == MODE_POSITION) begin
					err_sum_q <= sum_next;
					first_q   <= 1'b0;
					if (first_q) begin
						err_prev_q <= err;
					end
				end else begin
					err_prev_q <= err_last_q;
				end
			end
			if (adv4) begin
				drive_held_q <= y_out;
			end
		end
	end

	// Stage 3: products, floor-scaled by an arithmetic shift
	always_comb begin
		prod_p = PPW'(gain_p_q) * PPW'(p_x_s2);
		prod_i = IPW'(gain_i_q) * IPW'(i_x_s2);
		prod_d = DPW'(gain_d_q) * DPW'(d_x_s2);
	end

	// Stage 4: integral clamp, sum, drive clamp, dead band
	always_comb begin
		ilim = IPW'($signed({1'b0, integral_limit_q}));
		if (term_i_s3 > ilim) begin
			term_i_cl = ilim;
		end else if (term_i_s3 < -ilim) begin
			term_i_cl = -ilim;
		end else begin
			term_i_cl = term_i_s3;
		end

		held  = (mode_q == MODE_INCREMENTAL) ? YW'(drive_held_q) : '0;
		y_sum = YW'(term_p_s3) + YW'(term_i_cl) + YW'(term_d_s3) + held;

		lim = YW'($signed({1'b0, drive_limit_q}));
		if (y_sum > lim) begin
			y_cl = lim;
		end else if (y_sum < -lim) begin
			y_cl = -lim;
		end else begin
			y_cl = y_sum;
		end

		y_out = dz_s3 ? '0 : DRIVE_W'(y_cl);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= sample.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Payload registers: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (rdy1 && sample.valid) begin
			setpoint_s1 <= sample.setpoint;
			measured_s1 <= sample.measured;
		end
		if (adv2) begin
			p_x_s2 <= p_x;
			i_x_s2 <= i_x;
			d_x_s2 <= d_x;
			dz_s2  <= CW'(err_mag) < CW'(dead_band_q);
		end
		if (rdy3 && v_s2) begin
			term_p_s3 <= prod_p >>> GAIN_FRAC_BITS;
			term_i_s3 <= prod_i >>> GAIN_FRAC_BITS;
			term_d_s3 <= prod_d >>> GAIN_FRAC_BITS;
			dz_s3     <= dz_s2;
		end
		if (adv4) begin
			drive_s4 <= y_out;
		end
	end

	// Held drive never leaves the current drive limit
	a_held_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(drive_held_q <= $signed({1'b0, drive_limit_q})) &&
		(drive_held_q >= -$signed({1'b0, drive_limit_q})))
		else $error("held drive outside drive limit");

	// Input stalls only when every stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with an empty stage");

	// A dead-band transaction leaves as zero
	a_dead_band_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv4 && dz_s3) |=> (result.drive == '0))
		else $error("dead band transaction gave a nonzero drive");

	// Incremental form never touches the error sum
	a_incr_sum_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_INCREMENTAL && !cfg_hit) |=> $stable(err_sum_q))
		else $error("error sum changed in incremental form");

	// First position-form transaction clears the first-sample flag
	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && mode_q == MODE_POSITION && !cfg_hit) |=> !first_q)
		else $error("first-sample flag not cleared");

endmodule

// ----- tb/pid_controller_pos_incr_unit_test.sv -----
module pid_controller_pos_incr_unit_test;
	import pidpi_pkg::*;

	localparam int SAMPLE_W       = 16;
	localparam int FRAC_BITS      = 8;
	localparam int CLK_PERIOD     = 20;
	localparam int PIPE_LATENCY   = 3;
	localparam int RAND_PHASES    = 15;
	localparam longint TIMEOUT_CYCLES = 1_000_000;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	// Index 7 has no register behind it: writes there must leave everything alone.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sp;
		logic signed [SAMPLE_W-1:0] ms;
	} sample_t;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pidpi_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) smp_if ();
	pidpi_drive_if drv_if ();

	pid_controller_pos_incr_unit #(
		.SAMPLE_WIDTH  (SAMPLE_W),
		.GAIN_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.sample  (smp_if.sink),
		.result  (drv_if.source)
	);

	// Samples waiting to be offered, and drives predicted for accepted samples.
	sample_t                    pending_q[$];
	logic signed [DRIVE_W-1:0]  drive_expect_q[$];

	// Controller settings as the block should hold them.
	pid_mode_t                  ctl_mode;
	logic signed [GAIN_W-1:0]   kp, ki, kd;
	logic [LIMIT_W-1:0]         out_lim, int_lim;
	logic [DBAND_W-1:0]         dband;

	// Loop state: error sum, the two previous errors, the kept drive, seed flag.
	longint                     err_sum, err_last, err_prev, drive_hold;
	bit                         seed_pending;

	bit                         idle_on = 1'b1;
	int                         gap_left;
	int                         stall_left;
	int                         mismatch_count = 0;
	sample_t                    drv_item;
	logic signed [DRIVE_W-1:0]  want_drive;

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	function automatic void clear_loop_state();
		err_sum      = 0;
		err_last     = 0;
		err_prev     = 0;
		drive_hold   = 0;
		seed_pending = 1'b1;
	endfunction

	// Q8.8 gain times value, floored (arithmetic shift of a signed product).
	function automatic longint gain_mul(logic signed [GAIN_W-1:0] g, longint x);
		return (longint'(g) * x) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Work out the drive for one sample and advance the loop state.
	function automatic logic signed [DRIVE_W-1:0] next_drive(
		logic signed [SAMPLE_W-1:0] sp,
		logic signed [SAMPLE_W-1:0] ms
	);
		longint e, y, mag, lim, ilim;
		e    = longint'(sp) - longint'(ms);
		lim  = longint'(out_lim);
		ilim = longint'(int_lim);
		if (ctl_mode == MODE_POSITION) begin
			// Seed both past errors from the first sample so D starts at zero.
			if (seed_pending) begin
				err_last     = e;
				err_prev     = e;
				seed_pending = 1'b0;
			end
			err_sum = err_sum + e;
			if (err_sum > SUM_MAX)
				err_sum = SUM_MAX;
			if (err_sum < SUM_MIN)
				err_sum = SUM_MIN;
			y = gain_mul(kp, e) + clamp_mag(gain_mul(ki, err_sum), ilim)
			  + gain_mul(kd, e - err_last);
			y = clamp_mag(y, lim);
			err_last = e;
		end else begin
			// Incremental form: step the kept drive; the seed flag is untouched.
			y = drive_hold + gain_mul(kp, e - err_last)
			  + clamp_mag(gain_mul(ki, e), ilim)
			  + gain_mul(kd, e + err_prev - 2 * err_last);
			y = clamp_mag(y, lim);
			err_prev = err_last;
			err_last = e;
		end
		// Dead band zeroes the drive, and the zero is what gets kept.
		mag = (e < 0) ? -e : e;
		if (mag < longint'(dband))
			y = 0;
		drive_hold = y;
		return y[DRIVE_W-1:0];
	endfunction

	// Register write: one cycle with the enable high; the model follows at once,
	// which is safe because writes only happen while the block is empty.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		bit known;
		known = 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			REG_MODE:           ctl_mode = pid_mode_t'(data[0]);
			REG_GAIN_P:         kp = data;
			REG_GAIN_I:         ki = data;
			REG_GAIN_D:         kd = data;
			REG_DRIVE_LIMIT:    out_lim = data[LIMIT_W-1:0];
			REG_INTEGRAL_LIMIT: int_lim = data[LIMIT_W-1:0];
			REG_DEAD_BAND:      dband = data;
			default:            known = 1'b0;
		endcase
		if (known)
			clear_loop_state();
	endtask

	task automatic cfg_done();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(int sp, int ms);
		pending_q.push_back('{SAMPLE_W'(sp), SAMPLE_W'(ms)});
	endtask

	// Hold until every queued sample went in and every drive came back;
	// optionally let the pipeline settle before touching the registers.
	task automatic wait_drained(bit settle);
		do
			@(negedge clk);
		while (pending_q.size() != 0 || smp_if.valid || drive_expect_q.size() != 0);
		if (settle)
			repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return '0;
			3:       return CFG_DATA_W'($urandom());
			default: return CFG_DATA_W'($urandom_range(0, 1024) - 512);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 16'hFFFF;
			2:       return 16'h7FFF;
			3:       return CFG_DATA_W'($urandom());
			default: return CFG_DATA_W'($urandom_range(1, 4000));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dead_band();
		case ($urandom_range(0, 7))
			0:       return 16'hFFFF;
			1:       return CFG_DATA_W'($urandom());
			2, 3:    return CFG_DATA_W'($urandom_range(1, 600));
			default: return '0;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_edge();
		case ($urandom_range(0, 3))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	// Mostly errors near the dead band edge, with full-range and extreme samples.
	function automatic sample_t pick_sample(int span);
		sample_t s;
		int delta;
		s.ms = SAMPLE_W'($urandom());
		case ($urandom_range(0, 5))
			0: s.sp = SAMPLE_W'($urandom());
			1: begin
				s.sp = SAMPLE_W'($urandom());
				s.ms = '0;
			end
			2: begin
				s.sp = pick_edge();
				s.ms = pick_edge();
			end
			default: begin
				delta = int'($urandom_range(0, 2 * span)) - span;
				s.sp  = SAMPLE_W'(int'(s.ms) + delta);
			end
		endcase
		return s;
	endfunction

	// Sample driver: predict on every accepted transaction, then offer the next
	// queued sample, with random gaps between transactions while idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_if.valid <= 1'b0;
			gap_left     <= 0;
		end else begin
			if (smp_if.valid && smp_if.ready)
				drive_expect_q.push_back(next_drive(smp_if.setpoint, smp_if.measured));
			if (!smp_if.valid || smp_if.ready) begin
				if (gap_left > 0) begin
					smp_if.valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (pending_q.size() > 0) begin
					drv_item         = pending_q.pop_front();
					smp_if.valid    <= 1'b1;
					smp_if.setpoint <= drv_item.sp;
					smp_if.measured <= drv_item.ms;
					if (idle_on && $urandom_range(0, 5) == 0)
						gap_left <= $urandom_range(1, 5);
				end else begin
					smp_if.valid <= 1'b0;
				end
			end
		end
	end

	// Drive monitor: compare each accepted transaction against the oldest
	// prediction; stall the result channel in random bursts while idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_if.ready <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (drv_if.valid && drv_if.ready) begin
				if (drive_expect_q.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("drive %0d arrived with no sample outstanding", drv_if.drive);
				end else begin
					want_drive = drive_expect_q.pop_front();
					if (drv_if.drive !== want_drive) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= 10)
							$display("drive mismatch: expected %0d, got %0d",
								want_drive, drv_if.drive);
					end
				end
			end
			if (stall_left > 0) begin
				drv_if.ready <= 1'b0;
				stall_left   <= stall_left - 1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				drv_if.ready <= 1'b0;
				stall_left   <= $urandom_range(0, 4);
			end else begin
				drv_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] value;
		int n;
		int span;
		smp_if.valid    = 1'b0;
		smp_if.setpoint = '0;
		smp_if.measured = '0;
		drv_if.ready    = 1'b0;
		ctl_mode = MODE_POSITION;
		kp       = '0;
		ki       = '0;
		kd       = '0;
		out_lim  = 15'h7FFF;
		int_lim  = 15'h7FFF;
		dband    = '0;
		clear_loop_state();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset defaults: all gains zero, so even extreme errors give no drive.
		push_sample(32767, -32768);
		push_sample(-32768, 32767);
		wait_drained(1'b1);

		// Position form; the upper mode bits must be ignored. The first sample
		// seeds the past errors; a small negative error checks floor rounding.
		write_reg(REG_MODE, 16'hFFFE);
		write_reg(REG_GAIN_P, 16'h0100);
		write_reg(REG_GAIN_I, 16'h0040);
		write_reg(REG_GAIN_D, 16'hFF80);
		write_reg(REG_DRIVE_LIMIT, 16'hFFFF);
		write_reg(REG_INTEGRAL_LIMIT, 16'd2000);
		write_reg(REG_DEAD_BAND, 16'd0);
		cfg_done();
		push_sample(1000, 0);
		push_sample(1200, 200);
		push_sample(32767, -32768);
		push_sample(-32768, 32767);
		push_sample(0, 0);
		push_sample(-5, 0);
		wait_drained(1'b1);

		// A write to the unused index must not clear the loop state.
		write_reg(CFG_IDX_SPARE, 16'hFFFF);
		cfg_done();
		push_sample(300, 0);
		push_sample(-300, 0);
		wait_drained(1'b1);

		// Dead band edges on both signs, then the widest band.
		write_reg(REG_DEAD_BAND, 16'd500);
		cfg_done();
		push_sample(499, 0);
		push_sample(500, 0);
		push_sample(0, 499);
		push_sample(0, 500);
		wait_drained(1'b1);
		write_reg(REG_DEAD_BAND, 16'hFFFF);
		cfg_done();
		push_sample(32767, -32768);
		push_sample(32767, -32767);
		wait_drained(1'b1);

		// Zero limits: drive limit first, then the integral limit alone.
		write_reg(REG_DEAD_BAND, 16'd0);
		write_reg(REG_DRIVE_LIMIT, 16'd0);
		cfg_done();
		push_sample(1000, 0);
		wait_drained(1'b1);
		write_reg(REG_DRIVE_LIMIT, 16'h7FFF);
		write_reg(REG_INTEGRAL_LIMIT, 16'd0);
		cfg_done();
		push_sample(1000, 0);
		wait_drained(1'b1);

		// Incremental form.
		write_reg(REG_MODE, 16'h0001);
		write_reg(REG_GAIN_P, 16'h0100);
		write_reg(REG_GAIN_I, 16'h0080);
		write_reg(REG_GAIN_D, 16'h0040);
		write_reg(REG_INTEGRAL_LIMIT, 16'h7FFF);
		cfg_done();
		push_sample(1000, 0);
		push_sample(2000, 500);
		push_sample(-32768, 32767);
		push_sample(32767, -32768);
		push_sample(0, 0);
		wait_drained(1'b1);

		// Random phases: a fresh mix of settings, then a run of samples. The
		// last two phases run with no idling on either side.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
			for (int r = REG_MODE; r <= REG_DEAD_BAND; r++) begin
				if ($urandom_range(0, 3) != 0) begin
					case (r)
						REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:  value = pick_gain();
						REG_DRIVE_LIMIT, REG_INTEGRAL_LIMIT: value = pick_limit();
						REG_DEAD_BAND:                       value = pick_dead_band();
						default:                             value = CFG_DATA_W'($urandom());
					endcase
					write_reg(CFG_IDX_W'(r), value);
				end
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom()));
			cfg_done();
			span = (dband != 0 && dband < 30000) ? int'(dband) + 8 : 400;
			n = $urandom_range(60, 140);
			for (int k = 0; k < n; k++) begin
				// Sometimes hold the sender until every drive is back.
				if (k == n / 2 && $urandom_range(0, 1) == 1)
					wait_drained(1'b0);
				pending_q.push_back(pick_sample(span));
			end
			wait_drained(1'b1);
		end

		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (mismatch_count == 0 && drive_expect_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
